// File: sv/memory_region_carve_and_sort_unit_assert.svh
// ----------------------------------------------------------------------------
// Region carve and sort unit assertion macros
// Shared concurrent assertion forms used by the RTL.
// ----------------------------------------------------------------------------
`ifndef MEMORY_REGION_CARVE_AND_SORT_UNIT_ASSERT_SVH
`define MEMORY_REGION_CARVE_AND_SORT_UNIT_ASSERT_SVH

// implication checked every cycle outside reset
`define MRCS_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define MRCS_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: sv/mrcs_pkg.sv
// ----------------------------------------------------------------------------
// Region carve and sort package
// Shared constants and types.
// ----------------------------------------------------------------------------
package mrcs_pkg;
    localparam int unsigned DEF_TABLE_SLOTS = 32;
    localparam int unsigned ADDR_W = 64;
    localparam int unsigned KIND_W = 32;
    localparam int unsigned RB_W = 32;
    localparam int unsigned RL_W = 33;
    localparam int unsigned CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_RES_BASE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_RES_LEN = 1'b1;

    typedef struct packed {
        logic [ADDR_W-1:0] base;
        logic [ADDR_W-1:0] len;
        logic [KIND_W-1:0] kind;
    } region_t;
endpackage

// File: sv/mrcs_table.sv
// ----------------------------------------------------------------------------
// Region carve and sort table
// Sorted region store. Insert walks slots from the top through the read and compare
// states, shifting larger bases up; emit reads one slot per request.
// ----------------------------------------------------------------------------
module mrcs_table #(
    parameter int unsigned TABLE_SLOTS = mrcs_pkg::DEF_TABLE_SLOTS
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 ins_start,
    input  mrcs_pkg::region_t    ins_region,
    output logic                 ins_busy,
    input  logic                 clear,
    input  logic                 rd_en,
    input  logic [$clog2(TABLE_SLOTS)-1:0] rd_addr,
    output mrcs_pkg::region_t    rd_data,
    output logic [$clog2(TABLE_SLOTS+1)-1:0] count,
    output logic                 dropped
);
    import mrcs_pkg::*;
    localparam int unsigned IW = $clog2(TABLE_SLOTS);
    localparam int unsigned CW = $clog2(TABLE_SLOTS + 1);

    typedef enum logic [3:0] {
        T_IDLE = 4'b0001,
        T_READ = 4'b0010,
        T_CMP  = 4'b0100,
        T_PUT  = 4'b1000
    } tstate_t;

    region_t mem [TABLE_SLOTS];
    tstate_t state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] pos_reg, pos_next;
    logic dropped_reg, dropped_next;
    region_t item_reg;
    region_t rdq_reg;
    logic wr_en;
    logic [IW-1:0] wr_addr;
    region_t wr_data;
    logic [IW-1:0] mrd_addr;
    logic [CW-1:0] pos_m1;

    assign pos_m1 = pos_reg - CW'(1);

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        pos_next = pos_reg;
        dropped_next = dropped_reg;
        wr_en = 1'b0;
        wr_addr = pos_reg[IW-1:0];
        wr_data = item_reg;
        mrd_addr = rd_addr;
        case (state_reg)
            T_IDLE:
            begin
                if (clear)
                begin
                    count_next = '0;
                    dropped_next = 1'b0;
                end
                else if (ins_start)
                begin
                    if (count_reg >= CW'(TABLE_SLOTS))
                        dropped_next = 1'b1;
                    else if (count_reg == '0)
                    begin
                        wr_en = 1'b1;
                        wr_addr = '0;
                        wr_data = ins_region;
                        count_next = CW'(1);
                    end
                    else
                    begin
                        pos_next = count_reg;
                        state_next = T_READ;
                    end
                end
            end
            T_READ:
            begin
                mrd_addr = pos_m1[IW-1:0];
                state_next = T_CMP;
            end
            T_CMP:
            begin
                wr_en = 1'b1;
                if (rdq_reg.base > item_reg.base)
                begin
                    wr_data = rdq_reg;
                    pos_next = pos_m1;
                    if (pos_m1 == '0)
                        state_next = T_PUT;
                    else
                        state_next = T_READ;
                end
                else
                begin
                    state_next = T_IDLE;
                    count_next = count_reg + CW'(1);
                end
            end
            T_PUT:
            begin
                wr_en = 1'b1;
                state_next = T_IDLE;
                count_next = count_reg + CW'(1);
            end
            default:
                state_next = T_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en || state_reg == T_READ)
            rdq_reg <= mem[mrd_addr];
        if (state_reg == T_IDLE && ins_start)
            item_reg <= ins_region;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= T_IDLE;
            count_reg <= '0;
            pos_reg <= '0;
            dropped_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            pos_reg <= pos_next;
            dropped_reg <= dropped_next;
        end
    end

    assign ins_busy = (state_reg != T_IDLE);
    assign rd_data = rdq_reg;
    assign count = count_reg;
    assign dropped = dropped_reg;

    `include "memory_region_carve_and_sort_unit_assert.svh"
    `MRCS_ASSERT_IMP(a_cnt_bound, 1'b1, count_reg <= CW'(TABLE_SLOTS))
    `MRCS_ASSERT_NXT(a_clr, (state_reg == T_IDLE) && clear, count_reg == '0 && !dropped_reg)
    `MRCS_ASSERT_IMP(a_pos, (state_reg == T_READ) || (state_reg == T_CMP), pos_reg != '0 && pos_reg <= count_reg)
endmodule

// File: sv/memory_region_carve_and_sort_unit.sv
// ----------------------------------------------------------------------------
// Memory region carve and sort unit
// Removes a reserved range from memory map entries, keeps pieces sorted by
// base, and emits the table after the final entry.
// ----------------------------------------------------------------------------
// s_tready is low while an entry is in work: in the reserve, piece and wait states
// after the accepting edge, and while each piece that goes into the table walks
// it, a read and compare step per stored slot with a larger base and one more to
// stop (a put step instead in slot 0; no walk when the table is empty or full).
// A final entry emits the table, a read and output step per slot, as m_tready allows.
module memory_region_carve_and_sort_unit #(
    parameter int unsigned TABLE_SLOTS = mrcs_pkg::DEF_TABLE_SLOTS
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [159:0] s_tdata,  // region_base, region_len, region_kind
    input  logic         s_tlast,  // final_entry
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [167:0] m_tdata,  // out_base, out_len, out_kind, overflowed, pad
    output logic         m_tlast,  // out_last
    input  logic         cfg_we,
    input  logic [mrcs_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [32:0]  cfg_data
);
    import mrcs_pkg::*;
    localparam int unsigned IW = $clog2(TABLE_SLOTS);
    localparam int unsigned CW = $clog2(TABLE_SLOTS + 1);

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_RES  = 7'b0000010,
        S_P1   = 7'b0000100,
        S_P2   = 7'b0001000,
        S_RD   = 7'b0010000,
        S_OUT  = 7'b0100000,
        S_WAIT = 7'b1000000
    } state_t;

    state_t state_reg, state_next;
    logic [RB_W-1:0] rbase_reg;
    logic [RL_W-1:0] rlen_reg;
    logic [ADDR_W-1:0] eb_reg, ee_reg;
    logic [KIND_W-1:0] kind_reg;
    logic fin_reg;
    logic p1_reg, p2_reg;
    logic [IW-1:0] idx_reg, idx_next;
    region_t p1r, p2r;

    logic ins_start, ins_busy, clear, rd_en, dropped;
    region_t ins_region, rd_data;
    logic [CW-1:0] count;
    logic [IW-1:0] rd_addr;

    logic [ADDR_W-1:0] kb, ke, klen, len, ee;
    logic [ADDR_W-1:0] in_b, in_l;

    assign in_b = s_tdata[63:0];
    assign in_l = s_tdata[127:64];
    assign klen = (rlen_reg == '0) ? 64'd1 : {31'd0, rlen_reg};
    assign kb = {32'd0, rbase_reg};
    assign ke = kb + klen - 64'd1;
    assign len = (in_l - 64'd1 > ~in_b) ? (~in_b + 64'd1) : in_l;
    assign ee = in_b + len - 64'd1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rbase_reg <= '0;
            rlen_reg <= RL_W'(1);
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_RES_BASE)
                rbase_reg <= cfg_data[RB_W-1:0];
            else
                rlen_reg <= cfg_data;
        end
    end

    // an entry starting exactly at the reserved base and running past it
    // keeps an empty low piece, not the high part
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            eb_reg <= in_b;
            ee_reg <= ee;
            kind_reg <= s_tdata[159:128];
            fin_reg <= s_tlast;
            if (in_l == '0)
            begin
                p1_reg <= 1'b0;
                p2_reg <= 1'b0;
            end
            else if (ke < in_b || ee < kb)
            begin
                p1_reg <= 1'b1;
                p2_reg <= 1'b0;
            end
            else if (kb <= in_b && ee <= ke)
            begin
                p1_reg <= 1'b0;
                p2_reg <= 1'b0;
            end
            else if (in_b < kb && ke < ee)
            begin
                p1_reg <= 1'b1;
                p2_reg <= 1'b1;
            end
            else if (kb < in_b)
            begin
                p1_reg <= 1'b0;
                p2_reg <= 1'b1;
            end
            else
            begin
                p1_reg <= 1'b1;
                p2_reg <= 1'b0;
            end
        end
    end

    // piece 1: whole entry if disjoint else low part; piece 2: high part
    always_comb
    begin
        p1r.kind = kind_reg;
        p2r.kind = kind_reg;
        if (ke < eb_reg || ee_reg < kb)
        begin
            p1r.base = eb_reg;
            p1r.len = ee_reg - eb_reg + 64'd1;
        end
        else
        begin
            p1r.base = eb_reg;
            p1r.len = kb - eb_reg;
        end
        p2r.base = ke + 64'd1;
        p2r.len = ee_reg - ke;
    end

    always_comb
    begin
        state_next = state_reg;
        idx_next = idx_reg;
        ins_start = 1'b0;
        ins_region = p1r;
        clear = 1'b0;
        rd_en = 1'b0;
        rd_addr = idx_reg;
        case (state_reg)
            S_IDLE:
                if (s_tvalid)
                    state_next = S_RES;
            S_RES:
            begin
                if (count == '0)
                begin
                    ins_start = 1'b1;
                    ins_region.base = kb;
                    ins_region.len = klen;
                    ins_region.kind = '0;
                end
                state_next = S_P1;
            end
            S_P1:
                if (!ins_busy)
                begin
                    ins_start = p1_reg;
                    state_next = S_P2;
                end
            S_P2:
                if (!ins_busy)
                begin
                    ins_start = p2_reg;
                    ins_region = p2r;
                    state_next = S_WAIT;
                end
            S_WAIT:
                if (!ins_busy)
                begin
                    idx_next = '0;
                    if (fin_reg)
                        state_next = S_RD;
                    else
                        state_next = S_IDLE;
                end
            S_RD:
            begin
                rd_en = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
                if (m_tready)
                begin
                    if (CW'(idx_reg) + CW'(1) == count)
                    begin
                        clear = 1'b1;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        idx_next = idx_reg + IW'(1);
                        state_next = S_RD;
                    end
                end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            idx_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg <= idx_next;
        end
    end

    mrcs_table #(.TABLE_SLOTS(TABLE_SLOTS)) u_table (
        .clk(clk), .rst_n(rst_n), .ins_start(ins_start), .ins_region(ins_region),
        .ins_busy(ins_busy), .clear(clear), .rd_en(rd_en), .rd_addr(rd_addr),
        .rd_data(rd_data), .count(count), .dropped(dropped)
    );

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = (state_reg == S_OUT);
    assign m_tlast = (CW'(idx_reg) + CW'(1) == count);
    assign m_tdata = {7'd0, dropped, rd_data.kind, rd_data.len, rd_data.base};

    `include "memory_region_carve_and_sort_unit_assert.svh"
    `MRCS_ASSERT_IMP(a_excl, 1'b1, !(s_tready && m_tvalid))
    `MRCS_ASSERT_IMP(a_out_cnt, m_tvalid, CW'(idx_reg) < count)
    `MRCS_ASSERT_NXT(a_acc, s_tvalid && s_tready, state_reg == S_RES)
endmodule
